FILE: sv/ssid_pkg.sv
// ssid_pkg: shared types and constants for the sorted set insert block
// entry record, cell control/status structs, status codes, register map
// no dependencies
package ssid_pkg;

    localparam int DIM_W         = 4;
    localparam int NUM_W         = 11;
    localparam int KEY_W         = DIM_W + NUM_W;
    localparam int TAG_W         = 16;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 6;
    localparam int FILL_W        = 7;
    localparam int CAP_W         = 7;
    localparam int DEPTH_DEFAULT = 64;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // register index, taken from paddr above the byte offset
    localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] dim;
        logic [NUM_W-1:0] num;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic load_new;  // take the offered entry
        logic shift;     // take the lower neighbour's entry
    } t_cell_ctl;

    typedef struct packed {
        logic lt;        // held key below the offered key
        logic eq;        // held key equal to the offered key
    } t_cell_stat;

endpackage

FILE: sv/sorted_set_insert_dedup_core.sv
// sorted_set_insert_dedup_core: sorted key table with duplicate check, built as a row of cells
// depends on ssid_pkg and ssid_cell
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  input    | in        | i_valid / o_stall  | i_key_dim, i_key_num, i_tag
//  result   | out       | o_valid / i_stall  | o_status, o_position, o_fill
//  config   | in        | psel/penable/pready| paddr, pwdata, prdata
//
// each transaction first captures the key; then every cell compares its key at once and
// the row shifts up by one slot
// the next transaction can be taken once the result is written, if that result is not stalled
// reset clears the fill count and sets capacity to 64; slot contents are left as
// they are and are only read below the fill count, so there is no clearing pass
// a stalled result holds in the output register; the input is stalled while
// the compare cycle runs or while a result waits to be taken
module sorted_set_insert_dedup_core
    import ssid_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_stall,
    input  logic [DIM_W-1:0]    i_key_dim,
    input  logic [NUM_W-1:0]    i_key_num,
    input  logic [TAG_W-1:0]    i_tag,

    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [POS_W-1:0]    o_position,
    output logic [FILL_W-1:0]   o_fill,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int CW = $clog2(DEPTH + 1);           // fill count width
    localparam int IW = $clog2(DEPTH);               // slot index width
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;   // limit compare width

    typedef enum logic {
        S_IDLE,
        S_CMP
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [CAP_W-1:0]      r_capacity;
    t_entry                r_new;
    logic                  r_full;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [POS_W-1:0]      r_position;
    logic [FILL_W-1:0]     r_fill;

    t_entry                w_entry [DEPTH];
    t_cell_stat            w_stat  [DEPTH];
    t_cell_ctl             w_ctl   [DEPTH];
    logic [DEPTH-1:0]      w_edge;
    logic                  w_any_eq;
    logic                  w_do_insert;
    logic [IW-1:0]         w_pos;
    logic                  w_full_now;
    logic                  w_accept;
    logic                  w_cfg_write;
    logic [CW-1:0]         n_count;

    // ---------------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[ADDR_W-1:2] == REG_CAPACITY)
                         ? DATA_W'(r_capacity) : '0;

    // ---------------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------------
    // output register is free in the compare cycle: a new transaction is only
    // taken when the previous result is gone or leaves at the same edge
    assign o_stall  = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign w_accept = i_valid && !o_stall;

    // full when the fill reaches capacity, or the row itself is full
    assign w_full_now = (LW'(r_count) >= LW'(r_capacity)) || (r_count >= CW'(DEPTH));

    // ---------------------------------------------------------------------
    // row of cells
    // ---------------------------------------------------------------------
    // the held keys are sorted, so the lt flags form a prefix; the first cell
    // that is not below the key marks the insert point (or the duplicate)
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic w_prev_lt;
        if (g == 0) begin : g_first
            assign w_prev_lt = 1'b1;
        end else begin : g_rest
            assign w_prev_lt = w_stat[g-1].lt;
        end

        assign w_edge[g]          = !w_stat[g].lt && w_prev_lt;
        assign w_ctl[g].load_new  = w_do_insert && w_edge[g];
        assign w_ctl[g].shift     = w_do_insert && !w_stat[g].lt && !w_prev_lt;

        ssid_cell u_cell (
            .i_clk      (i_clk),
            .i_new      (r_new),
            .i_prev     ((g == 0) ? r_new : w_entry[(g == 0) ? 0 : g-1]),
            .i_occupied (r_count > CW'(g)),
            .i_ctl      (w_ctl[g]),
            .o_entry    (w_entry[g]),
            .o_stat     (w_stat[g])
        );
    end

    always_comb begin
        w_any_eq = 1'b0;
        w_pos    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_any_eq = w_any_eq | w_stat[i].eq;
            w_pos    = w_pos | (w_edge[i] ? IW'(i) : '0);
        end
    end

    assign w_do_insert = (r_state == S_CMP) && !r_full && !w_any_eq;
    assign n_count     = w_do_insert ? r_count + CW'(1) : r_count;

    // ---------------------------------------------------------------------
    // sequencer and result register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_write && (paddr[ADDR_W-1:2] == REG_CAPACITY)) begin
                r_capacity <= pwdata[CAP_W-1:0];
            end

            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_new.dim <= i_key_dim;
                        r_new.num <= i_key_num;
                        r_new.tag <= i_tag;
                        r_full    <= w_full_now;
                        r_state   <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_count     <= n_count;
                    r_out_valid <= 1'b1;
                    r_fill      <= FILL_W'(n_count);
                    if (r_full) begin
                        r_status   <= STATUS_FULL;
                        r_position <= '0;
                    end else begin
                        r_status   <= w_any_eq ? STATUS_DUPLICATE : STATUS_INSERTED;
                        r_position <= POS_W'(w_pos);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_position = r_position;
    assign o_fill     = r_fill;

endmodule

FILE: sv/ssid_cell.sv
// ssid_cell: one table slot, holds an entry and compares it with the offered key
// depends on ssid_pkg
module ssid_cell
    import ssid_pkg::*;
(
    input  logic       i_clk,
    input  t_entry     i_new,
    input  t_entry     i_prev,
    input  logic       i_occupied,
    input  t_cell_ctl  i_ctl,
    output t_entry     o_entry,
    output t_cell_stat o_stat
);

    t_entry           r_entry;
    logic [KEY_W-1:0] w_held_key;
    logic [KEY_W-1:0] w_new_key;

    assign w_held_key = {r_entry.dim, r_entry.num};
    assign w_new_key  = {i_new.dim, i_new.num};

    // empty slots never match and never sit below the new key
    assign o_stat.lt = i_occupied && (w_held_key < w_new_key);
    assign o_stat.eq = i_occupied && (w_held_key == w_new_key);
    assign o_entry   = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_prev;
        end
    end

endmodule

FILE: sv/ssid_checker.sv
// ssid_checker: port-level checks for the sorted set insert block, bound to the top level
// depends on ssid_pkg
module ssid_checker
    import ssid_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [POS_W-1:0]    o_position,
    input logic [FILL_W-1:0]   o_fill
);

    // a full table reports slot zero
    a_full_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_FULL) |-> o_position == '0)
        else $error("full result with nonzero position");

    // an insert always leaves at least one entry held
    a_insert_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_INSERTED) |-> o_fill != '0)
        else $error("insert result with zero fill");

    // one transaction at a time: the compare cycle stalls the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken during compare cycle");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_position)
            && $stable(o_fill))
        else $error("stalled result changed");

endmodule

bind sorted_set_insert_dedup_core ssid_checker u_ssid_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_status   (o_status),
    .o_position (o_position),
    .o_fill     (o_fill)
);
